// ----- rtl/fat_dir_entry_decoder_assert.svh -----
// Assertion macros shared by the directory entry decoder modules.
`ifndef FAT_DIR_ENTRY_DECODER_ASSERT_SVH
`define FAT_DIR_ENTRY_DECODER_ASSERT_SVH
`ifndef SYNTHESIS
`define FDE_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("fde assertion failed");
`define FDE_ASSERT_NEVER(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("fde forbidden condition seen");
`else
`define FDE_ASSERT(label, prop)
`define FDE_ASSERT_NEVER(label, expr)
`endif
`endif

// ----- rtl/fde_pkg.sv -----
// Shared constants, types and helper functions of the directory entry decoder.
`default_nettype none
package fde_pkg;

  // Entry layout.
  localparam int NAME_LEN       = 11;
  localparam int ENTRY_BYTES    = 32;
  localparam int POS_W          = $clog2(ENTRY_BYTES);
  localparam int IDX_W          = $clog2(NAME_LEN + 1);
  localparam int ATTR_POS       = 11;
  localparam int CLUS_LO_POS    = 26;
  localparam int CLUS_HI_POS    = 27;
  localparam int SIZE_B0_POS    = 28;
  localparam int SIZE_B1_POS    = 29;
  localparam int SIZE_B2_POS    = 30;
  localparam int LAST_POS       = ENTRY_BYTES - 1;
  localparam int DIR_ATTR_BIT   = 4;

  // Depth of the request queue between front and back.
  localparam int QUEUE_DEPTH    = 2;

  typedef logic [7:0] char_t;

  // Character codes.
  localparam char_t CHAR_NUL    = 8'd0;
  localparam char_t CHAR_SPACE  = 8'd32;
  localparam char_t CHAR_DOT    = 8'd46;
  localparam char_t CHAR_DIG_LO = 8'd48;
  localparam char_t CHAR_DIG_HI = 8'd57;
  localparam char_t CHAR_UC_LO  = 8'd65;
  localparam char_t CHAR_UC_HI  = 8'd90;
  localparam char_t CHAR_LC_LO  = 8'd97;
  localparam char_t CHAR_LC_HI  = 8'd122;

  // One accepted directory entry, ready to be turned into name characters.
  typedef struct packed {
    char_t [NAME_LEN-1:0] name;
    logic                 is_dir;
    logic [15:0]          cluster;
    logic [31:0]          size;
  } entry_t;

  // A name byte must be a digit, a letter or a space.
  function automatic logic name_byte_ok(input char_t c);
    return c inside {[CHAR_DIG_LO:CHAR_DIG_HI], [CHAR_UC_LO:CHAR_UC_HI],
                     [CHAR_LC_LO:CHAR_LC_HI], CHAR_SPACE};
  endfunction

endpackage
`default_nettype wire

// ----- rtl/fde_queue.sv -----
// Small request queue between the byte front end and the name emitter.
`default_nettype none
`include "fat_dir_entry_decoder_assert.svh"
module fde_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  output logic            push_ready,
  input  fde_pkg::entry_t push_entry,
  output logic            pop_valid,
  input  logic            pop_ready,
  output fde_pkg::entry_t pop_entry
);

  localparam int PTR_W = (fde_pkg::QUEUE_DEPTH > 1) ? $clog2(fde_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(fde_pkg::QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(fde_pkg::QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(fde_pkg::QUEUE_DEPTH);

  fde_pkg::entry_t  slots [fde_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  // Handshake on both sides.
  assign push_ready = (count != CNT_FULL);
  assign pop_valid  = (count != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_entry  = slots[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Entry storage; no reset is needed for the payload.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  `FDE_ASSERT(q_count_up, (do_push && !do_pop) |=> (count == $past(count) + 1'b1))
  `FDE_ASSERT_NEVER(q_overflow, count > CNT_FULL)

endmodule
`default_nettype wire

// ----- rtl/fde_front.sv -----
// Front end: collects directory bytes into entries and checks the name.
`default_nettype none
`include "fat_dir_entry_decoder_assert.svh"
module fde_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      entry_byte,
  output logic            push_valid,
  input  logic            push_ready,
  output fde_pkg::entry_t push_entry
);

  localparam int PW = fde_pkg::POS_W;
  localparam logic [PW-1:0] P_ATTR   = PW'(fde_pkg::ATTR_POS);
  localparam logic [PW-1:0] P_CL_LO  = PW'(fde_pkg::CLUS_LO_POS);
  localparam logic [PW-1:0] P_CL_HI  = PW'(fde_pkg::CLUS_HI_POS);
  localparam logic [PW-1:0] P_SZ0    = PW'(fde_pkg::SIZE_B0_POS);
  localparam logic [PW-1:0] P_SZ1    = PW'(fde_pkg::SIZE_B1_POS);
  localparam logic [PW-1:0] P_SZ2    = PW'(fde_pkg::SIZE_B2_POS);
  localparam logic [PW-1:0] P_LAST   = PW'(fde_pkg::LAST_POS);
  localparam logic [PW-1:0] P_NAME_N = PW'(fde_pkg::NAME_LEN);

  logic [PW-1:0]  pos;
  logic [PW-1:0]  pos_next;
  fde_pkg::char_t name [fde_pkg::NAME_LEN];
  logic [7:0]     attr;
  logic [15:0]    cluster;
  logic [23:0]    size_lo;
  logic           all_ok;
  logic           at_last;
  logic           accept;

  assign at_last  = (pos == P_LAST);
  assign pos_next = pos + 1'b1;

  // Every name byte must pass the character check; a zero first byte fails it too.
  always_comb begin
    all_ok = 1'b1;
    for (int i = 0; i < fde_pkg::NAME_LEN; i++) begin
      all_ok = all_ok && fde_pkg::name_byte_ok(name[i]);
    end
  end

  // Only the final byte of a kept entry needs room in the queue.
  assign in_ready   = !at_last || push_ready || !all_ok;
  assign accept     = in_valid && in_ready;
  assign push_valid = in_valid && at_last && all_ok;

  always_comb begin
    for (int i = 0; i < fde_pkg::NAME_LEN; i++) begin
      push_entry.name[i] = name[i];
    end
    push_entry.is_dir  = attr[fde_pkg::DIR_ATTR_BIT];
    push_entry.cluster = cluster;
    push_entry.size    = {entry_byte, size_lo};
  end

  // Byte position within the entry wraps every entry.
  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (accept) begin
      pos <= pos_next;
    end
  end

  // Field capture.
  always_ff @(posedge clk) begin
    if (accept) begin
      if (pos < P_NAME_N) begin
        name[pos[fde_pkg::IDX_W-1:0]] <= entry_byte;
      end
      case (pos)
        P_ATTR:  attr           <= entry_byte;
        P_CL_LO: cluster[7:0]   <= entry_byte;
        P_CL_HI: cluster[15:8]  <= entry_byte;
        P_SZ0:   size_lo[7:0]   <= entry_byte;
        P_SZ1:   size_lo[15:8]  <= entry_byte;
        P_SZ2:   size_lo[23:16] <= entry_byte;
        default: ;
      endcase
    end
  end

  `FDE_ASSERT(fr_ready_mid, !at_last |-> in_ready)
  `FDE_ASSERT(fr_push_only_last, (push_valid && push_ready) |-> (accept && at_last))

endmodule
`default_nettype wire

// ----- rtl/fde_back.sv -----
// Back end: queued entry to display-name chars, one per cycle unless stalled.
`default_nettype none
`include "fat_dir_entry_decoder_assert.svh"
module fde_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            pop_valid,
  output logic            pop_ready,
  input  fde_pkg::entry_t pop_entry,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [7:0]      name_char,
  output logic            char_valid,
  output logic            is_directory,
  output logic [15:0]     first_cluster,
  output logic [31:0]     file_size,
  output logic            last_char
);

  localparam int IW = fde_pkg::IDX_W;
  localparam logic [IW-1:0] K_END = IW'(fde_pkg::NAME_LEN);

  logic            busy;
  fde_pkg::entry_t cur;
  logic [IW-1:0]   k;
  fde_pkg::char_t  ext [fde_pkg::NAME_LEN + 1];
  fde_pkg::char_t  ch;
  logic            ch_space;
  logic [IW-1:0]   next_word;
  fde_pkg::char_t  step_char;
  logic            step_valid;
  logic [IW-1:0]   step_k;
  logic            step_last;
  logic            advance;
  logic            load_out;
  logic            take;

  // Name padded with one space past its end, so lookahead stays in range.
  always_comb begin
    for (int i = 0; i < fde_pkg::NAME_LEN; i++) begin
      ext[i] = cur.name[i];
    end
    ext[fde_pkg::NAME_LEN] = fde_pkg::CHAR_SPACE;
  end

  assign ch       = ext[k];
  assign ch_space = (ch == fde_pkg::CHAR_SPACE);

  // First non-space position after the current one, or the end of the name.
  always_comb begin
    next_word = K_END;
    for (int j = fde_pkg::NAME_LEN - 1; j >= 0; j--) begin
      if ((IW'(j) > k) && (ext[j] != fde_pkg::CHAR_SPACE)) begin
        next_word = IW'(j);
      end
    end
  end

  // One output character per step.
  always_comb begin
    step_char  = ch;
    step_valid = 1'b1;
    step_k     = k + 1'b1;
    step_last  = 1'b0;
    if (!cur.is_dir) begin
      // A file turns each run of spaces into a single dot.
      if (ch_space) begin
        step_char = fde_pkg::CHAR_DOT;
        step_k    = next_word;
      end
      step_last = (step_k == K_END);
    end else if (ch_space) begin
      // A directory whose name begins with a space gives the empty name.
      step_char  = fde_pkg::CHAR_NUL;
      step_valid = 1'b0;
      step_last  = 1'b1;
    end else begin
      step_last = (ext[k + 1'b1] == fde_pkg::CHAR_SPACE);
    end
  end

  assign advance   = !out_valid || out_ready;
  assign load_out  = busy && advance;
  assign pop_ready = !busy || (load_out && step_last);
  assign take      = pop_valid && pop_ready;

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      k         <= '0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        out_valid <= busy;
      end
      if (take) begin
        busy <= 1'b1;
        k    <= '0;
      end else if (load_out) begin
        k <= step_k;
        if (step_last) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // Current entry and output register payload.
  always_ff @(posedge clk) begin
    if (take) begin
      cur <= pop_entry;
    end
    if (load_out) begin
      name_char     <= step_char;
      char_valid    <= step_valid;
      is_directory  <= cur.is_dir;
      first_cluster <= cur.cluster;
      file_size     <= cur.size;
      last_char     <= step_last;
    end
  end

  `FDE_ASSERT(bk_done_idle, (load_out && step_last && !pop_valid) |=> !busy)
  `FDE_ASSERT_NEVER(bk_index_past_end, busy && (k >= K_END))

endmodule
`default_nettype wire

// ----- rtl/fat_dir_entry_decoder.sv -----
// Top level of the FAT directory entry decoder: front end, queue and name emitter.
// Input: one directory byte per cycle; input stalls only at an entry's final byte
// when the two-entry queue is full. A kept entry passes the queue and the emitter's
// entry register, then one character per cycle leaves the output register while
// out_ready is high. Synchronous rst clears byte position, queue and output valid;
// no clearing pass is needed and a request is taken in the cycle after reset.
`default_nettype none
module fat_dir_entry_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  entry_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  name_char,
  output logic        char_valid,
  output logic        is_directory,
  output logic [15:0] first_cluster,
  output logic [31:0] file_size,
  output logic        last_char
);

  logic            push_valid;
  logic            push_ready;
  fde_pkg::entry_t push_entry;
  logic            pop_valid;
  logic            pop_ready;
  fde_pkg::entry_t pop_entry;

  fde_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .entry_byte (entry_byte),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry)
  );

  fde_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_entry  (pop_entry)
  );

  fde_back u_back (
    .clk           (clk),
    .rst           (rst),
    .pop_valid     (pop_valid),
    .pop_ready     (pop_ready),
    .pop_entry     (pop_entry),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .name_char     (name_char),
    .char_valid    (char_valid),
    .is_directory  (is_directory),
    .first_cluster (first_cluster),
    .file_size     (file_size),
    .last_char     (last_char)
  );

endmodule
`default_nettype wire

// ----- verif/tb_top.sv -----
// Self-checking testbench for the FAT directory entry decoder.
`timescale 1ns / 1ps
module tb_top;

  localparam int LONG_HOLD    = 600;
  localparam int DRAIN_CYCLES = 20;
  localparam int MAX_REPORTS  = 10;

  // How the expected characters of an entry are obtained.
  typedef enum logic [1:0] {BY_PREDICTOR, LIT_DROPPED, LIT_NAME} check_mode_t;

  // One row of the directed table: a whole 32-byte entry.
  typedef struct packed {
    logic [87:0] name;
    logic [7:0]  attr;
    logic [15:0] cluster;
    logic [31:0] size;
    logic [7:0]  fill;
    check_mode_t mode;
    logic [87:0] text;
  } dir_row_t;

  // One byte request, with what is needed to check the entry it closes.
  typedef struct packed {
    logic [7:0]  data;
    logic        closes;
    check_mode_t mode;
    logic [87:0] text;
    logic        dir;
    logic [15:0] cluster;
    logic [31:0] size;
  } byte_req_t;

  // One display-name character with its entry metadata.
  typedef struct packed {
    fde_pkg::char_t ch;
    logic           cv;
    logic           dir;
    logic [15:0]    cluster;
    logic [31:0]    size;
    logic           last;
  } name_char_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  entry_byte;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  name_char;
  logic        char_valid;
  logic        is_directory;
  logic [15:0] first_cluster;
  logic [31:0] file_size;
  logic        last_char;

  byte_req_t   cur_req;
  name_char_t  expected_chars[$];
  name_char_t  decoded_chars[$];
  int          err_cnt;
  bit          calm;
  bit          long_hold;

  // Decoder state as seen by the predictor.
  logic [4:0]     pos_q;
  fde_pkg::char_t name_bytes [fde_pkg::NAME_LEN];
  logic [7:0]     attr_bits;
  logic [15:0]    cluster_acc;
  logic [23:0]    size_acc;

  // Directed entries: naming rules, a free slot and the extremes of the metadata.
  dir_row_t dir_rows [0:3] = '{
    '{"README  TXT", 8'h20, 16'h0002, 32'h0000_1234, 8'h00, LIT_NAME, "README.TXT"},
    '{"           ", 8'h10, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF, LIT_NAME, 88'h0},
    '{" a b  c d e", 8'h00, 16'hBEEF, 32'h1234_5678, 8'hC3, BY_PREDICTOR, 88'h0},
    '{{8'h00, "BCDEFGHIJK"}, 8'h00, 16'h0000, 32'h0000_0000, 8'hA5, LIT_DROPPED, 88'h0}
  };

  fat_dir_entry_decoder uut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .entry_byte    (entry_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .name_char     (name_char),
    .char_valid    (char_valid),
    .is_directory  (is_directory),
    .first_cluster (first_cluster),
    .file_size     (file_size),
    .last_char     (last_char)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Absolute time limit for the whole run.
  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // A name byte is valid if it is a digit, a letter or a space.
  function automatic bit name_char_legal(input logic [7:0] c);
    return (c >= fde_pkg::CHAR_DIG_LO && c <= fde_pkg::CHAR_DIG_HI) ||
           (c >= fde_pkg::CHAR_UC_LO && c <= fde_pkg::CHAR_UC_HI) ||
           (c >= fde_pkg::CHAR_LC_LO && c <= fde_pkg::CHAR_LC_HI) ||
           c == fde_pkg::CHAR_SPACE;
  endfunction

  // Predictor: absorbs one directory byte and, on an entry's final byte, queues its name.
  function automatic void decode_dir_byte(input logic [7:0] b);
    logic [4:0]  p;
    logic [31:0] fsize;
    bit          ok;
    int          k;
    name_char_t  r;
    p = pos_q;
    pos_q = pos_q + 5'd1;
    if (p < fde_pkg::NAME_LEN) begin
      name_bytes[p] = b;
    end else if (p == fde_pkg::ATTR_POS) begin
      attr_bits = b;
    end else if (p == fde_pkg::CLUS_LO_POS) begin
      cluster_acc[7:0] = b;
    end else if (p == fde_pkg::CLUS_HI_POS) begin
      cluster_acc[15:8] = b;
    end else if (p >= fde_pkg::SIZE_B0_POS && p <= fde_pkg::SIZE_B2_POS) begin
      size_acc[8*(p-fde_pkg::SIZE_B0_POS) +: 8] = b;
    end else if (p == fde_pkg::LAST_POS) begin
      fsize = {b, size_acc};
      ok = (name_bytes[0] != fde_pkg::CHAR_NUL);
      for (k = 0; k < fde_pkg::NAME_LEN; k++) ok &= name_char_legal(name_bytes[k]);
      if (ok) begin
        r.cv = 1'b1;
        r.dir = attr_bits[fde_pkg::DIR_ATTR_BIT];
        r.cluster = cluster_acc;
        r.size = fsize;
        r.last = 1'b0;
        if (!r.dir) begin
          // Files: every run of spaces collapses to one dot.
          k = 0;
          while (k < fde_pkg::NAME_LEN) begin
            if (name_bytes[k] != fde_pkg::CHAR_SPACE) begin
              r.ch = name_bytes[k];
              decoded_chars = {decoded_chars, r};
              k++;
            end else begin
              r.ch = fde_pkg::CHAR_DOT;
              decoded_chars = {decoded_chars, r};
              while (k < fde_pkg::NAME_LEN && name_bytes[k] == fde_pkg::CHAR_SPACE) k++;
            end
          end
        end else begin
          // Directories: the name ends at the first space.
          for (k = 0; k < fde_pkg::NAME_LEN && name_bytes[k] != fde_pkg::CHAR_SPACE; k++)
          begin
            r.ch = name_bytes[k];
            decoded_chars = {decoded_chars, r};
          end
        end
        if (decoded_chars.size() == 0) begin
          r.ch = fde_pkg::CHAR_NUL;
          r.cv = 1'b0;
          decoded_chars = {decoded_chars, r};
        end
        r = decoded_chars[decoded_chars.size()-1];
        r.last = 1'b1;
        decoded_chars[decoded_chars.size()-1] = r;
      end
    end
  endfunction

  // Expected characters typed into a directed row, metadata taken from the same row.
  function automatic void push_literal_name(input byte_req_t q);
    name_char_t r;
    bit         started;
    int         k;
    started = 1'b0;
    r.dir = q.dir;
    r.cluster = q.cluster;
    r.size = q.size;
    r.cv = 1'b1;
    r.last = 1'b0;
    for (k = fde_pkg::NAME_LEN - 1; k >= 0; k--) begin
      if (q.text[8*k +: 8] != fde_pkg::CHAR_NUL || started) begin
        started = 1'b1;
        r.ch = q.text[8*k +: 8];
        expected_chars = {expected_chars, r};
      end
    end
    if (!started) begin
      r.ch = fde_pkg::CHAR_NUL;
      r.cv = 1'b0;
      expected_chars = {expected_chars, r};
    end
    r = expected_chars[expected_chars.size()-1];
    r.last = 1'b1;
    expected_chars[expected_chars.size()-1] = r;
  endfunction

  // Monitor: checks accepted characters, then predicts from the accepted byte.
  always @(posedge clk) begin
    name_char_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_chars.size() == 0) begin
          err_cnt++;
          if (err_cnt <= MAX_REPORTS)
            $display("%0t: unexpected character %h (valid %b, last %b)", $realtime,
                     name_char, char_valid, last_char);
        end else begin
          want = expected_chars.pop_front();
          if (name_char !== want.ch || char_valid !== want.cv || is_directory !== want.dir ||
              first_cluster !== want.cluster || file_size !== want.size ||
              last_char !== want.last) begin
            err_cnt++;
            if (err_cnt <= MAX_REPORTS) begin
              $display("%0t: mismatch exp ch=%h cv=%b dir=%b clus=%h size=%h last=%b",
                       $realtime, want.ch, want.cv, want.dir, want.cluster, want.size,
                       want.last);
              $display("%0t: mismatch got ch=%h cv=%b dir=%b clus=%h size=%h last=%b",
                       $realtime, name_char, char_valid, is_directory, first_cluster,
                       file_size, last_char);
            end
          end
        end
      end
      if (in_valid && in_ready) begin
        decode_dir_byte(entry_byte);
        if (cur_req.mode == BY_PREDICTOR) begin
          expected_chars = {expected_chars, decoded_chars};
        end else if (cur_req.closes && cur_req.mode == LIT_NAME) begin
          push_literal_name(cur_req);
        end
        decoded_chars.delete();
      end
    end
  end

  // Receiver: a long hold-off on request, random stall bursts, none once calm.
  initial begin
    out_ready = 1'b0;
    @(negedge rst);
    @(negedge clk);
    forever begin
      if (long_hold) begin
        long_hold = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(negedge clk);
      end
    end
  end

  // Offers one byte request, with an optional idle burst in front, and waits for acceptance.
  task automatic send_byte(input byte_req_t q);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    in_valid <= 1'b1;
    entry_byte <= q.data;
    cur_req <= q;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Sends one whole 32-byte entry.
  task automatic send_entry(input logic [87:0] nm, input logic [7:0] attr,
                            input logic [15:0] clus, input logic [31:0] size,
                            input logic [7:0] fill, input bit fill_rand,
                            input check_mode_t mode, input logic [87:0] text);
    byte_req_t q;
    int        p;
    q.mode = mode;
    q.text = text;
    q.dir = attr[fde_pkg::DIR_ATTR_BIT];
    q.cluster = clus;
    q.size = size;
    for (p = 0; p < fde_pkg::ENTRY_BYTES; p++) begin
      if (p < fde_pkg::NAME_LEN) q.data = nm[8*(fde_pkg::NAME_LEN-1-p) +: 8];
      else if (p == fde_pkg::ATTR_POS) q.data = attr;
      else if (p == fde_pkg::CLUS_LO_POS) q.data = clus[7:0];
      else if (p == fde_pkg::CLUS_HI_POS) q.data = clus[15:8];
      else if (p >= fde_pkg::SIZE_B0_POS) q.data = size[8*(p-fde_pkg::SIZE_B0_POS) +: 8];
      else q.data = fill_rand ? 8'($urandom) : fill;
      q.closes = (p == fde_pkg::LAST_POS);
      send_byte(q);
    end
  endtask

  // Random entry: mostly well-formed names, the rest broken names or raw noise.
  task automatic send_random_entry(input bit well_formed);
    logic [87:0] nm;
    logic [7:0]  c;
    int          sel;
    int          k;
    sel = well_formed ? 0 : $urandom_range(0, 19);
    for (k = 0; k < fde_pkg::NAME_LEN; k++) begin
      if (sel >= 17) begin
        c = 8'($urandom);
      end else begin
        case ($urandom_range(0, 4))
          0: c = 8'($urandom_range(fde_pkg::CHAR_DIG_LO, fde_pkg::CHAR_DIG_HI));
          1: c = 8'($urandom_range(fde_pkg::CHAR_UC_LO, fde_pkg::CHAR_UC_HI));
          2: c = 8'($urandom_range(fde_pkg::CHAR_LC_LO, fde_pkg::CHAR_LC_HI));
          default: c = fde_pkg::CHAR_SPACE;
        endcase
      end
      nm[8*(fde_pkg::NAME_LEN-1-k) +: 8] = c;
    end
    if (sel >= 12 && sel <= 14) begin
      // One illegal byte somewhere in the name.
      do c = 8'($urandom); while (name_char_legal(c));
      k = $urandom_range(0, fde_pkg::NAME_LEN - 1);
      nm[8*(fde_pkg::NAME_LEN-1-k) +: 8] = c;
    end else if (sel == 15 || sel == 16) begin
      // Free slot marker in the first name byte.
      nm[8*(fde_pkg::NAME_LEN-1) +: 8] = fde_pkg::CHAR_NUL;
    end
    send_entry(nm, 8'($urandom), 16'($urandom), 32'($urandom), 8'h00, 1'b1,
               BY_PREDICTOR, 88'h0);
  endtask

  // Main sequence: reset, directed table, random entry, then drain and verdict.
  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    entry_byte = 8'h00;
    cur_req = '0;
    err_cnt = 0;
    calm = 1'b0;
    // The receiver holds off from reset onwards, so the three kept table entries fill
    // the back end and the queue, and the random entry's final byte stalls the input.
    long_hold = 1'b1;
    pos_q = '0;
    attr_bits = '0;
    cluster_acc = '0;
    size_acc = '0;
    foreach (name_bytes[i]) name_bytes[i] = fde_pkg::CHAR_NUL;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_rows[i])
      send_entry(dir_rows[i].name, dir_rows[i].attr, dir_rows[i].cluster, dir_rows[i].size,
                 dir_rows[i].fill, 1'b0, dir_rows[i].mode, dir_rows[i].text);

    // Final stretch without any idling on either side.
    calm = 1'b1;
    send_random_entry(1'b1);
    in_valid <= 1'b0;

    while (expected_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
